### hdl/lagrr_pkg.sv
// ----------------------------------------------------------------------------
// lagrr_pkg: shared types and constants of the lag and reservoir router
// Field widths, register indexes and the control word of one delay cell.
// ----------------------------------------------------------------------------
package lagrr_pkg;

   localparam int SAMPLE_W    = 32;   // Q16.16 flow samples
   localparam int GAIN_W      = 17;   // Q0.16 / Q1.16 coefficients
   localparam int LAG_STEPS_W = 9;    // lag register width
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;   // widest register

   localparam logic [CSR_INDEX_W-1:0] CSR_LAG_STEPS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFLOW_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN = 2'd2;

   // Control of one delay cell in the current cycle.
   typedef struct packed {
      logic advance;      // load a new value this cycle
      logic take_insert;  // cell is the tail: load the insert value, not the neighbor
   } lagrr_cell_ctl_type;

endpackage

### hdl/lagrr_cell.sv
// ----------------------------------------------------------------------------
// lagrr_cell: one entry of the delay chain
// Holds one sample and loads either its right neighbor or the insert value.
// ----------------------------------------------------------------------------
module lagrr_cell
   import lagrr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  lagrr_cell_ctl_type        ctl,
   input  logic signed [SAMPLE_W-1:0] insert_data,
   input  logic signed [SAMPLE_W-1:0] neighbor_data,
   output logic signed [SAMPLE_W-1:0] data
);

   logic signed [SAMPLE_W-1:0] data_ff;
   logic signed [SAMPLE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.advance) begin
         data_in = ctl.take_insert ? insert_data : neighbor_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

### hdl/lagrr_reservoir.sv
// ----------------------------------------------------------------------------
// lagrr_reservoir: linear reservoir pipeline
// Sum, inflow product, then feedback product with rounding and saturation.
// ----------------------------------------------------------------------------
module lagrr_reservoir
   import lagrr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] in_delayed,
   input  logic        [GAIN_W-1:0]   inflow_gain,
   input  logic signed [GAIN_W-1:0]   feedback_gain,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [SAMPLE_W-1:0] out_outflow
);

   localparam int SUM_W  = SAMPLE_W + 1;
   localparam int PROD_W = SUM_W + GAIN_W + 1;
   localparam int FB_W   = SAMPLE_W + GAIN_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int RND_W  = ACC_W - 16;

   logic                       a_valid_ff, a_valid_in;
   logic signed [SUM_W-1:0]    a_sum_ff;
   logic signed [SAMPLE_W-1:0] a_delayed_ff;
   logic signed [SAMPLE_W-1:0] prev_delayed_ff;
   logic                       b_valid_ff;
   logic signed [PROD_W-1:0]   b_prod_ff;
   logic signed [SAMPLE_W-1:0] b_delayed_ff;
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_value_ff;
   logic signed [SAMPLE_W-1:0] prev_outflow_ff;

   logic                       out_move, b_move, a_move, in_fire;
   logic signed [FB_W-1:0]     fb_prod;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RND_W-1:0]    rounded;
   logic signed [SAMPLE_W-1:0] saturated;
   logic signed [SAMPLE_W-1:0] result;

   // a stage moves whenever the stage after it is empty or moving
   assign out_move = !out_valid_ff || out_ready;
   assign b_move   = !b_valid_ff || out_move;
   assign a_move   = !a_valid_ff || b_move;
   assign in_ready = a_move;
   assign in_fire  = in_valid && a_move;
   assign a_valid_in = in_fire;

   assign fb_prod   = feedback_gain * prev_outflow_ff;
   assign acc       = ACC_W'(b_prod_ff) + ACC_W'(fb_prod) + ACC_W'(32768);
   assign rounded   = acc[ACC_W-1:16];

   always_comb begin
      if ((rounded[RND_W-1:SAMPLE_W-1] == '0) || (rounded[RND_W-1:SAMPLE_W-1] == '1)) begin
         saturated = rounded[SAMPLE_W-1:0];
      end else if (rounded[RND_W-1]) begin
         saturated = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         saturated = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      result = (inflow_gain == '0) ? b_delayed_ff : saturated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         prev_delayed_ff <= '0;
         prev_outflow_ff <= '0;
      end else begin
         if (a_move) begin
            a_valid_ff <= a_valid_in;
         end
         if (in_fire) begin
            prev_delayed_ff <= in_delayed;
         end
         if (b_move) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_move) begin
            out_valid_ff <= b_valid_ff;
         end
         if (out_move && b_valid_ff) begin
            prev_outflow_ff <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         a_sum_ff     <= SUM_W'(in_delayed) + SUM_W'(prev_delayed_ff);
         a_delayed_ff <= in_delayed;
      end
      if (b_move) begin
         b_prod_ff    <= a_sum_ff * $signed({1'b0, inflow_gain});
         b_delayed_ff <= a_delayed_ff;
      end
      if (out_move && b_valid_ff) begin
         out_value_ff <= result;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_outflow = out_value_ff;

endmodule

### hdl/lag_and_linear_reservoir_router.sv
// ----------------------------------------------------------------------------
// lag_and_linear_reservoir_router: lag line followed by a linear reservoir
// Delays each Q16.16 inflow sample by lag_steps - 1 steps, then routes it
// through a linear reservoir with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one inflow sample per transfer, rsp_* one outflow sample
//   per transfer, in the same order. Both use valid/ready.
//   csr_* writes lag_steps (0), inflow_gain (1) and feedback_gain (2) while
//   the block is idle; an inflow_gain of zero passes the delayed sample
//   straight through.
// Rate and pipeline:
//   One sample per cycle unless the rsp side stalls or the chain realigns. A
//   transferred sample passes three register stages (sum, inflow product,
//   feedback loop) before rsp_valid. The feedback product and rounding are
//   combinational, ahead of the output register.
//   Writing lag_steps makes the chain rotate back into place, one cell per
//   cycle, until the ring pointer is zero, with req_ready low throughout.
// Reset:
//   Clears the delay chain, the reservoir history and the registers
//   (lag_steps = 1, both gains zero). No clearing pass is needed.
// Stall:
//   A stalled rsp side holds its result; the pipeline keeps taking samples
//   until every stage is full, then req_ready drops.
// ----------------------------------------------------------------------------
module lag_and_linear_reservoir_router
   import lagrr_pkg::*;
#(
   parameter int LAG_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_inflow,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_outflow,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LAG_W = $clog2(LAG_DEPTH + 1);
   localparam int PTR_W = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;

   // Configuration registers
   logic [LAG_STEPS_W-1:0]     lag_steps_ff;
   logic [GAIN_W-1:0]          inflow_gain_ff;
   logic signed [GAIN_W-1:0]   feedback_gain_ff;

   // Chain geometry: cell k holds ring[(off + k) mod geom] for k < geom and
   // ring[k] beyond it. off is the ring pointer under that geometry.
   logic [LAG_W-1:0]           geom_ff, geom_in;
   logic [PTR_W-1:0]           off_ff, off_in;
   logic                       realign_ff, realign_in;
   logic [LAG_W-1:0]           lag_eff;
   logic [31:0]                lag_wide;
   logic [LAG_W-1:0]           off_next;

   logic                       accept, rotate, step;
   logic                       res_ready;
   logic signed [SAMPLE_W-1:0] insert_data;
   logic signed [SAMPLE_W-1:0] delayed;
   logic signed [SAMPLE_W-1:0] cell_q [LAG_DEPTH+1];
   lagrr_cell_ctl_type         cell_ctl [LAG_DEPTH];

   // Clamp the lag register to 1 .. LAG_DEPTH.
   always_comb begin
      if (lag_steps_ff == '0) begin
         lag_wide = 32'd1;
      end else if (32'(lag_steps_ff) > 32'(LAG_DEPTH)) begin
         lag_wide = 32'(LAG_DEPTH);
      end else begin
         lag_wide = 32'(lag_steps_ff);
      end
   end
   assign lag_eff = lag_wide[LAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_steps_ff     <= LAG_STEPS_W'(1);
         inflow_gain_ff   <= '0;
         feedback_gain_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LAG_STEPS:     lag_steps_ff     <= csr_wdata[LAG_STEPS_W-1:0];
            CSR_INFLOW_GAIN:   inflow_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= $signed(csr_wdata[GAIN_W-1:0]);
            default: ;
         endcase
      end
   end

   // Handshake: hold off samples while the chain rotates back into place.
   assign req_ready = res_ready && !realign_ff;
   assign accept    = req_valid && req_ready;
   assign rotate    = realign_ff && (off_ff != '0);
   assign step      = accept || rotate;

   // Samples enter at the tail; a rotation feeds the head back to the tail.
   assign insert_data = accept ? req_inflow : cell_q[0];

   // Fully delayed sample; a one-step lag reads the sample being written.
   assign delayed = (geom_ff == LAG_W'(1)) ? req_inflow : cell_q[1];

   assign off_next = LAG_W'(off_ff) + LAG_W'(1);

   always_comb begin
      geom_in    = geom_ff;
      off_in     = off_ff;
      realign_in = realign_ff;
      if (step) begin
         // advance the pointer modulo the chain geometry
         off_in = (off_next == geom_ff) ? '0 : off_next[PTR_W-1:0];
      end
      if (realign_ff && (off_ff == '0)) begin
         // chain is in absolute order: adopt the new lag
         geom_in    = lag_eff;
         realign_in = 1'b0;
      end
      if (csr_write && (csr_index == CSR_LAG_STEPS)) begin
         realign_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff    <= LAG_W'(1);
         off_ff     <= '0;
         realign_ff <= 1'b0;
      end else begin
         geom_ff    <= geom_in;
         off_ff     <= off_in;
         realign_ff <= realign_in;
      end
   end

   // Delay chain: cells below the tail shift left, the tail takes the insert.
   assign cell_q[LAG_DEPTH] = '0;

   for (genvar k = 0; k < LAG_DEPTH; k++) begin : g_cell
      localparam logic [LAG_W-1:0] IDX = LAG_W'(k);

      assign cell_ctl[k].advance     = step && (IDX < geom_ff);
      assign cell_ctl[k].take_insert = (IDX == (geom_ff - LAG_W'(1)));

      lagrr_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (cell_ctl[k]),
         .insert_data   (insert_data),
         .neighbor_data (cell_q[k+1]),
         .data          (cell_q[k])
      );
   end

   lagrr_reservoir u_reservoir (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid && !realign_ff),
      .in_ready      (res_ready),
      .in_delayed    (delayed),
      .inflow_gain   (inflow_gain_ff),
      .feedback_gain (feedback_gain_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_outflow   (rsp_outflow)
   );

   // A transfer always sees the chain laid out for the current lag.
   a_geom_matches: assert property (@(posedge clock) disable iff (reset)
      accept |-> (geom_ff == lag_eff))
      else $error("sample taken with stale chain geometry");

   // The pointer stays inside the chain geometry.
   a_off_in_range: assert property (@(posedge clock) disable iff (reset)
      LAG_W'(off_ff) < geom_ff)
      else $error("ring pointer beyond chain geometry");

   // A lag write blocks samples until the chain is realigned.
   a_lag_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_LAG_STEPS)) |=> !req_ready)
      else $error("sample accepted right after a lag write");

endmodule

### bench/tb_lag_and_linear_reservoir_router.sv
// ----------------------------------------------------------------------------
// tb_lag_and_linear_reservoir_router: self-checking bench for the router
// Drives inflow samples over a valid/ready channel and routes each accepted
// sample through a local model of the lag ring and linear reservoir. Every
// outflow transfer is matched against the oldest predicted outflow. Tests
// cover bypass, lag lengths, saturation, rounding ties, a long output stall
// and randomized configurations under changing idle patterns.
// ----------------------------------------------------------------------------
module tb_lag_and_linear_reservoir_router
   import lagrr_pkg::*;
();

   localparam int CLOCK_PERIOD   = 12;
   localparam int LAG_DEPTH      = 256;
   localparam int SETTLE_CYCLES  = 8;       // pipeline depth plus margin
   localparam int LONG_HOLD      = 150;     // output stall of the pressure test
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int MAX_REPORTS    = 20;

   localparam longint FLOW_MAX = 64'sd2147483647;
   localparam longint FLOW_MIN = -64'sd2147483648;

   localparam logic signed [SAMPLE_W-1:0] INFLOW_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] INFLOW_MIN = 32'sh8000_0000;

   // Block ports; the inputs are known from time zero.
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_inflow  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_outflow;
   logic                       csr_write   = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index   = CSR_LAG_STEPS;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;

   // Router model state: lag ring, head pointer and reservoir history.
   logic signed [SAMPLE_W-1:0] lag_ring [LAG_DEPTH];
   int unsigned                lag_head;
   logic signed [SAMPLE_W-1:0] last_delayed;
   logic signed [SAMPLE_W-1:0] last_outflow;
   logic [LAG_STEPS_W-1:0]     cfg_lag;
   logic [GAIN_W-1:0]          cfg_inflow_gain;
   logic signed [GAIN_W-1:0]   cfg_feedback_gain;

   // Predicted outflows, oldest first.
   logic signed [SAMPLE_W-1:0] expected_outflow [$];
   logic signed [SAMPLE_W-1:0] oldest_outflow;

   int error_count   = 0;
   int items_sent    = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // Long output stall: the test raises the request, the receiver counts it down.
   logic hold_request = 1'b0;
   int   hold_left    = 0;

   lag_and_linear_reservoir_router #(
      .LAG_DEPTH (LAG_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_inflow  (req_inflow),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_outflow (rsp_outflow),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Route one inflow sample through the model and return its outflow.
   // Store the sample at the head, advance the head, read the oldest entry,
   // then apply the reservoir unless the inflow gain is zero.
   function automatic logic signed [SAMPLE_W-1:0] route_sample(
      input logic signed [SAMPLE_W-1:0] inflow
   );
      int unsigned                span;
      logic signed [SAMPLE_W-1:0] delayed;
      logic signed [SAMPLE_W-1:0] routed;
      longint                     mix;
      // A lag of zero behaves as one; lags past the ring depth clamp to it.
      if (cfg_lag == 0)
         span = 1;
      else if (cfg_lag > LAG_DEPTH)
         span = LAG_DEPTH;
      else
         span = cfg_lag;
      if (lag_head >= span)
         lag_head = 0;
      lag_ring[lag_head] = inflow;
      lag_head = (lag_head + 1) % span;
      delayed = lag_ring[lag_head];
      if (cfg_inflow_gain == '0) begin
         routed = delayed;
      end else begin
         // Sum both products at 32 fraction bits, round once (ties up), saturate.
         mix = (longint'(delayed) + longint'(last_delayed)) * longint'(cfg_inflow_gain)
             + longint'(cfg_feedback_gain) * longint'(last_outflow);
         mix = (mix + 64'sd32768) >>> 16;
         if (mix > FLOW_MAX)
            routed = INFLOW_MAX;
         else if (mix < FLOW_MIN)
            routed = INFLOW_MIN;
         else
            routed = SAMPLE_W'(mix);
      end
      // Bypass updates the history as well, to the delayed value.
      last_delayed = delayed;
      last_outflow = routed;
      return routed;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_inflow();
      case ($urandom_range(7))
         0:       return INFLOW_MAX;
         1:       return INFLOW_MIN;
         2:       return SAMPLE_W'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         default: return $urandom();
      endcase
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic signed [SAMPLE_W-1:0] want,
                                  input logic signed [SAMPLE_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] outflow mismatch (%s): expected %0d, got %0d",
                  $realtime, what, want, got);
   endtask

   // Offer one sample; hold it until transferred, then log its outflow.
   // Leave req_valid high so back-to-back samples never toggle it in one step.
   task automatic send_inflow(input logic signed [SAMPLE_W-1:0] sample);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_inflow <= sample;
      do @(posedge clock); while (!req_ready);
      expected_outflow.push_back(route_sample(sample));
      items_sent++;
   endtask

   // Drop the request and wait until every predicted outflow has arrived.
   task automatic drain_router();
      req_valid <= 1'b0;
      while (expected_outflow.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0]  data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_LAG_STEPS: begin
            cfg_lag  = data[LAG_STEPS_W-1:0];
            lag_head = 0;
         end
         CSR_INFLOW_GAIN:   cfg_inflow_gain   = data[GAIN_W-1:0];
         CSR_FEEDBACK_GAIN: cfg_feedback_gain = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // Write all three registers once the block is idle. Write the lag last:
   // it starts the ring realignment, during which req_ready stays low.
   task automatic configure_router(input logic [LAG_STEPS_W-1:0] lag,
                                   input logic [GAIN_W-1:0]      inflow_gain,
                                   input logic [GAIN_W-1:0]      feedback_gain);
      drain_router();
      write_register(CSR_INFLOW_GAIN, CSR_DATA_W'(inflow_gain));
      write_register(CSR_FEEDBACK_GAIN, CSR_DATA_W'(feedback_gain));
      write_register(CSR_LAG_STEPS, CSR_DATA_W'(lag));
      csr_write <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Out of reset: lag of one and zero gain, so each sample comes straight back.
   task automatic test_reset_state();
      send_inflow(32'sd65536);
      send_inflow(-32'sd123456);
   endtask

   // Bypass with the field extremes and alternating bit patterns.
   task automatic test_bypass_extremes();
      send_inflow(INFLOW_MAX);
      send_inflow(INFLOW_MIN);
      send_inflow('0);
      send_inflow(-32'sd1);
      send_inflow(32'sh5555_5555);
      send_inflow(32'shAAAA_AAAA);
   endtask

   // Lag of zero acts as one, a lag of two delays one step, a lag past the
   // ring depth clamps to the depth.
   task automatic test_lag_lengths();
      configure_router(9'd0, '0, '0);
      send_inflow(32'sd7);
      send_inflow(32'sd8);
      configure_router(9'd2, '0, '0);
      send_inflow(32'sd100);
      send_inflow(32'sd200);
      send_inflow(32'sd300);
      configure_router(9'd511, '0, '0);
      send_inflow(32'sd1);
      send_inflow(32'sd2);
   endtask

   // Drive the reservoir into both saturation limits; also use an inflow
   // gain above one and the most negative feedback gain.
   task automatic test_saturation();
      configure_router(9'd1, 17'd65536, 17'h0FFFF);
      send_inflow(INFLOW_MAX);
      send_inflow(INFLOW_MAX);
      send_inflow(INFLOW_MAX);
      configure_router(9'd1, 17'd131071, 17'h10000);
      send_inflow(INFLOW_MIN);
      send_inflow(INFLOW_MIN);
   endtask

   // Exact half-LSB sums: a positive tie rounds up, a negative tie rounds to zero.
   task automatic test_rounding_ties();
      configure_router(9'd1, 17'd1, '0);
      send_inflow(32'sd16384);
      send_inflow(32'sd16384);
      send_inflow(-32'sd16384);
      send_inflow(-32'sd16384);
   endtask

   // Hold the output off for a long stretch while samples keep coming, so the
   // pipeline fills and the input stalls.
   task automatic test_backpressure();
      int saved_idle;
      saved_idle = req_idle_pct;
      configure_router(9'd4, 17'd40000, 17'd20000);
      req_idle_pct = 0;
      hold_request <= 1'b1;
      repeat (40) send_inflow(random_inflow());
      req_idle_pct = saved_idle;
   endtask

   // Random configurations, each followed by a burst of random samples.
   // Mostly short lags; sometimes a long lag with enough samples to wrap.
   task automatic test_random_routing(input int budget);
      int                     stop_at;
      int                     burst;
      logic [LAG_STEPS_W-1:0] lag;
      logic [GAIN_W-1:0]      inflow_gain;
      logic [GAIN_W-1:0]      feedback_gain;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(15))
            0:       lag = 9'd0;
            1:       lag = 9'd256;
            2:       lag = 9'd255;
            3:       lag = LAG_STEPS_W'($urandom_range(257, 511));
            4:       lag = LAG_STEPS_W'($urandom_range(17, 254));
            default: lag = LAG_STEPS_W'($urandom_range(1, 16));
         endcase
         case ($urandom_range(7))
            0:       inflow_gain = '0;
            1:       inflow_gain = 17'd65536;
            2:       inflow_gain = GAIN_W'($urandom_range(65537, 131071));
            default: inflow_gain = GAIN_W'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(7))
            0:       feedback_gain = 17'h10000;
            1:       feedback_gain = 17'h0FFFF;
            2:       feedback_gain = '0;
            default: feedback_gain = GAIN_W'($urandom_range(0, 131071));
         endcase
         configure_router(lag, inflow_gain, feedback_gain);
         burst = $urandom_range(8, 40);
         if (lag > 16 && $urandom_range(3) == 0)
            burst = ((lag > LAG_DEPTH) ? LAG_DEPTH : int'(lag)) + 8;
         // keep the total close to the budget
         if (burst > stop_at - items_sent)
            burst = stop_at - items_sent;
         repeat (burst) send_inflow(random_inflow());
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // Drive rsp_ready: honor a long hold when requested, else stall at random.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Match every outflow transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outflow.size() == 0) begin
            report_mismatch("no sample pending", '0, rsp_outflow);
         end else begin
            oldest_outflow = expected_outflow.pop_front();
            if (rsp_outflow !== oldest_outflow)
               report_mismatch("outflow", oldest_outflow, rsp_outflow);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // Model reset state matches the block's reset values.
      foreach (lag_ring[i])
         lag_ring[i] = '0;
      lag_head          = 0;
      last_delayed      = '0;
      last_outflow      = '0;
      cfg_lag           = 9'd1;
      cfg_inflow_gain   = '0;
      cfg_feedback_gain = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily.
      req_idle_pct  = 12;
      rsp_stall_pct = 60;
      test_reset_state();
      test_bypass_extremes();
      test_lag_lengths();
      test_saturation();
      test_rounding_ties();
      test_random_routing(170);

      // Swap the idle pattern.
      req_idle_pct  = 60;
      rsp_stall_pct = 12;
      test_backpressure();
      test_random_routing(170);

      // Full rate on both sides.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_routing(170);

      drain_router();
      if (error_count == 0)
         $display("lag_and_linear_reservoir_router verification clean");
      else
         $display("lag_and_linear_reservoir_router verification failed");
      $finish;
   end

   // Watchdog: a lost transfer never drains, so end the run here.
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("lag_and_linear_reservoir_router verification failed");
      $finish;
   end

endmodule
